// ----- src/mps_pkg.sv -----
// Shared types and constants for the modem power sequencer.
`default_nettype none

package mps_pkg;

  // Sequencer phases as reported in the result phase field.
  typedef enum logic [3:0] {
    PH_INIT    = 4'd0,
    PH_KEY     = 4'd1,
    PH_KEY2    = 4'd2,
    PH_WAIT    = 4'd3,
    PH_OK      = 4'd4,
    PH_ERR     = 4'd5,
    PH_OFF     = 4'd6,
    PH_RESTART = 4'd7,
    PH_SHUT    = 4'd8,
    PH_IDLE    = 4'd9
  } phase_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_HOLD     = 2'd0;
  localparam logic [1:0] REG_POWER_WAIT   = 2'd1;
  localparam logic [1:0] REG_RESTART_WAIT = 2'd2;
  localparam logic [1:0] REG_MAX_OFFS     = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] KEY_HOLD_RST     = 16'd500;
  localparam logic [15:0] POWER_WAIT_RST   = 16'd20000;
  localparam logic [15:0] RESTART_WAIT_RST = 16'd1000;
  localparam logic [3:0]  MAX_OFFS_RST     = 4'd5;

  // Saturation point of the power-off counter.
  localparam logic [3:0] OFF_COUNT_MAX = 4'd15;

  // Poll request fields.
  typedef struct packed {
    logic [9:0] elapsed_ms;
    logic       power_status;
    logic       fault_request;
  } in_t;

  // Result fields.
  typedef struct packed {
    logic       ready_res;
    logic       led_on;
    logic       dtr_level;
    logic       reset_line;
    logic       key_line;
    logic       supply_enable;
    logic       clear_link_state;
    logic       shutdown_request;
    logic [3:0] phase;
    logic [3:0] off_count;
  } out_t;

  // Current configuration as seen by the sequencer core.
  typedef struct packed {
    logic [15:0] key_hold_ms;
    logic [15:0] power_wait_ms;
    logic [15:0] restart_wait_ms;
    logic [3:0]  max_power_offs;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/mps_cfg.sv -----
// Configuration register file of the modem power sequencer.
`default_nettype none

module mps_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output mps_pkg::cfg_t    cfg
);

  mps_pkg::cfg_t cfg_r;

  // Registers are written by index; they return to their defaults on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_hold_ms     <= mps_pkg::KEY_HOLD_RST;
      cfg_r.power_wait_ms   <= mps_pkg::POWER_WAIT_RST;
      cfg_r.restart_wait_ms <= mps_pkg::RESTART_WAIT_RST;
      cfg_r.max_power_offs  <= mps_pkg::MAX_OFFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mps_pkg::REG_KEY_HOLD:     cfg_r.key_hold_ms     <= cfg_wdata;
        mps_pkg::REG_POWER_WAIT:   cfg_r.power_wait_ms   <= cfg_wdata;
        mps_pkg::REG_RESTART_WAIT: cfg_r.restart_wait_ms <= cfg_wdata;
        mps_pkg::REG_MAX_OFFS:     cfg_r.max_power_offs  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/mps_core.sv -----
// Phase machine, millisecond timer and pin levels of the modem power sequencer.
`default_nettype none

module mps_core #(
  parameter int TIMER_BITS = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire mps_pkg::in_t  req,
  input  wire mps_pkg::cfg_t cfg,
  output mps_pkg::out_t      res
);

  mps_pkg::phase_t         phase_r, phase_nxt, phase_eval;
  logic [TIMER_BITS-1:0]   timer_r, timer_nxt, timer_sum;
  logic [TIMER_BITS:0]     timer_wide;
  logic [3:0]              offs_r, offs_nxt, offs_inc;
  logic                    led_r, led_nxt;
  logic                    dtr_r, dtr_nxt;
  logic                    rst_line_r, rst_line_nxt;
  logic                    key_r, key_nxt;
  logic                    sup_r, sup_nxt;
  logic                    ready, clear, shut;
  logic                    key_done, wait_done, restart_done;

  // A fault request overrides the stored phase before evaluation.
  assign phase_eval = req.fault_request ? mps_pkg::PH_ERR : phase_r;

  // Saturating add of the elapsed time.
  assign timer_wide = {1'b0, timer_r} + (TIMER_BITS + 1)'(req.elapsed_ms);
  assign timer_sum  = timer_wide[TIMER_BITS] ? {TIMER_BITS{1'b1}}
                                             : timer_wide[TIMER_BITS-1:0];

  // Waits end only once the timer is strictly past the limit.
  assign key_done     = timer_sum > TIMER_BITS'(cfg.key_hold_ms);
  assign wait_done    = timer_sum > TIMER_BITS'(cfg.power_wait_ms);
  assign restart_done = timer_sum > TIMER_BITS'(cfg.restart_wait_ms);

  // Power-off counter holds at its top value.
  assign offs_inc = (offs_r == mps_pkg::OFF_COUNT_MAX) ? offs_r : offs_r + 4'd1;

  // One step of the phase machine.
  always_comb begin
    phase_nxt    = phase_eval;
    timer_nxt    = timer_sum;
    offs_nxt     = offs_r;
    led_nxt      = led_r;
    dtr_nxt      = dtr_r;
    rst_line_nxt = rst_line_r;
    key_nxt      = key_r;
    sup_nxt      = sup_r;
    ready        = 1'b0;
    clear        = 1'b0;
    shut         = 1'b0;
    case (phase_eval)
      mps_pkg::PH_INIT: begin
        clear        = 1'b1;
        led_nxt      = 1'b1;
        dtr_nxt      = 1'b1;
        rst_line_nxt = 1'b1;
        key_nxt      = 1'b1;
        sup_nxt      = 1'b1;
        timer_nxt    = '0;
        phase_nxt    = mps_pkg::PH_KEY;
      end
      mps_pkg::PH_KEY: begin
        if (key_done) begin
          key_nxt   = 1'b0;
          timer_nxt = '0;
          phase_nxt = mps_pkg::PH_KEY2;
        end
      end
      mps_pkg::PH_KEY2: begin
        if (key_done) begin
          key_nxt   = 1'b1;
          led_nxt   = 1'b0;
          timer_nxt = '0;
          phase_nxt = mps_pkg::PH_WAIT;
        end
      end
      mps_pkg::PH_WAIT: begin
        // A timeout wins over a status seen on the same poll.
        if (wait_done) begin
          phase_nxt = mps_pkg::PH_ERR;
        end else if (req.power_status) begin
          phase_nxt = mps_pkg::PH_OK;
          ready     = 1'b1;
        end
      end
      mps_pkg::PH_OK: begin
        if (!req.power_status) begin
          phase_nxt = mps_pkg::PH_ERR;
        end else begin
          ready = 1'b1;
        end
      end
      mps_pkg::PH_ERR: begin
        clear     = 1'b1;
        phase_nxt = mps_pkg::PH_OFF;
      end
      mps_pkg::PH_OFF: begin
        offs_nxt  = offs_inc;
        sup_nxt   = 1'b0;
        timer_nxt = '0;
        phase_nxt = (offs_inc >= cfg.max_power_offs) ? mps_pkg::PH_SHUT
                                                     : mps_pkg::PH_RESTART;
      end
      mps_pkg::PH_RESTART: begin
        if (restart_done) begin
          phase_nxt = mps_pkg::PH_INIT;
        end
      end
      mps_pkg::PH_SHUT: begin
        shut      = 1'b1;
        phase_nxt = mps_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = mps_pkg::PH_IDLE;
      end
    endcase
  end

  // State advances once for each request that is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mps_pkg::PH_INIT;
      timer_r    <= '0;
      offs_r     <= '0;
      led_r      <= 1'b0;
      dtr_r      <= 1'b0;
      rst_line_r <= 1'b0;
      key_r      <= 1'b0;
      sup_r      <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      offs_r     <= offs_nxt;
      led_r      <= led_nxt;
      dtr_r      <= dtr_nxt;
      rst_line_r <= rst_line_nxt;
      key_r      <= key_nxt;
      sup_r      <= sup_nxt;
    end
  end

  // Result of this step, taken by the output register.
  always_comb begin
    res.ready_res        = ready;
    res.led_on           = led_nxt;
    res.dtr_level        = dtr_nxt;
    res.reset_line       = rst_line_nxt;
    res.key_line         = key_nxt;
    res.supply_enable    = sup_nxt;
    res.clear_link_state = clear;
    res.shutdown_request = shut;
    res.phase            = phase_nxt;
    res.off_count        = offs_nxt;
  end

endmodule

`default_nettype wire

// ----- src/modem_power_sequencer.sv -----
// Top level of the modem power sequencer: request register, configuration registers, core and result register.
`default_nettype none

// Each request is one poll of the modem power sequencer. A request is held in
// an input register, evaluated by the phase machine and delivered from a
// result register. One request per cycle is sustained as long as results
// are taken. The input register frees as the result register frees, so a
// stall on the result side reaches in_stall in the same cycle. Configuration
// registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while the sequencer is idle, as the block itself does
// not enforce this.
module modem_power_sequencer #(
  parameter int TIMER_BITS = 17
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire mps_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output mps_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata
);

  mps_pkg::in_t  req_r;
  logic          req_valid_r;
  mps_pkg::out_t res, res_r;
  logic          res_valid_r;
  mps_pkg::cfg_t cfg;
  logic          advance, step_en, in_take;

  // The result register can load when empty or when its result is taken.
  assign advance  = !res_valid_r || !out_stall;
  assign step_en  = req_valid_r && advance;
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  mps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mps_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .req     (req_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Input request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (advance || !req_valid_r) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

// ----- src/mps_checker.sv -----
// Port-level assertions for the modem power sequencer and their bind.
`default_nettype none

module mps_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire mps_pkg::out_t out_data
);

  // A stalled result stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

  // Ready is only reported in the ok phase with the supply on.
  a_ready_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ready_res |->
      out_data.phase == mps_pkg::PH_OK && out_data.supply_enable)
    else $error("ready reported outside the ok phase");

  // A link clear comes from init (now key) or from error (now off).
  a_clear_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clear_link_state |->
      out_data.phase == mps_pkg::PH_KEY || out_data.phase == mps_pkg::PH_OFF)
    else $error("link clear in an unexpected phase");

  // A shutdown request leaves the sequencer idle with the supply off.
  a_shut_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.shutdown_request |->
      out_data.phase == mps_pkg::PH_IDLE && !out_data.supply_enable)
    else $error("shutdown request without idle phase");

endmodule

bind modem_power_sequencer mps_checker u_mps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
